// ===== rtl/core/round_robin_quantum_scheduler_core_defines.svh =====
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RRQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled in reset
`define RRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== rtl/core/rrqs_pkg.sv =====
package rrqs_pkg;

  localparam int BURST_W = 16;
  localparam int RES_W   = 24;
  localparam int FRAC_W  = 8;

  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_AVERAGE  = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_ZERO      = 3'd1,
    ST_FULL      = 3'd2,
    ST_REQUEUED  = 3'd3,
    ST_COMPLETED = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_AVERAGE   = 3'd6,
    ST_AVG_EMPTY = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [BURST_W-1:0] burst_time;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [RES_W-1:0] result_value;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/core/rrqs_cell.sv =====
module rrqs_cell
  import rrqs_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [BURST_W-1:0] load_data,
  input  logic [BURST_W-1:0] nbr_data,
  output logic [BURST_W-1:0] data_o
);

  logic [BURST_W-1:0] data_r;
  logic [BURST_W-1:0] data_nxt;

  always_comb begin
    priority if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== rtl/core/rrqs_div.sv =====
module rrqs_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              busy_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  num_nxt;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  den_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // one quotient bit per cycle
      num_nxt  = {num_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      step_nxt = step_r - 1'b1;
      busy_nxt = (step_r != STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = num_r;

endmodule

// ===== rtl/core/round_robin_quantum_scheduler_core.sv =====
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall   | in_item_t  (func, burst_time)
// out     | output    | out_valid/out_stall | out_item_t (status, result_value)
// cfg     | input     | cfg_we              | time_quantum
//
// add and dispatch: result loaded into the output register when the item is taken
// average: result from the serial divider, which yields one
//   quotient bit per cycle
// queue is a row of QUEUE_DEPTH cells shifting toward the head on dispatch
// synchronous active-low reset clears count, sum, quantum (to 1) and control
// a new item is taken only while idle and the output register is free or draining
module round_robin_quantum_scheduler_core
  import rrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [BURST_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = $clog2(QUEUE_DEPTH * 65535 + 1);
  localparam int NUM_W = SUM_W + FRAC_W;

  typedef enum logic [0:0] {
    S_IDLE,
    S_DIV
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic [BURST_W-1:0] quantum_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_item_r;
  out_item_t          out_item_nxt;

  logic               out_free;
  logic               accept;
  logic               shift_en;
  logic               load_en;
  logic [CNT_W-1:0]   load_idx;
  logic [BURST_W-1:0] load_data;
  logic [BURST_W-1:0] head;
  logic [BURST_W-1:0] head_rem;
  logic               div_start;
  logic               div_busy;
  logic [NUM_W-1:0]   div_quot;

  logic [BURST_W-1:0] cell_data [QUEUE_DEPTH];
  logic [BURST_W-1:0] nbr_data  [QUEUE_DEPTH];
  cell_ctl_t          cell_ctl  [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_data[i] = cell_data[i];
    end else begin : g_mid
      assign nbr_data[i] = cell_data[i+1];
    end
    assign cell_ctl[i].shift = shift_en;
    assign cell_ctl[i].load  = load_en && (load_idx == CNT_W'(i));
    rrqs_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_data (load_data),
      .nbr_data  (nbr_data[i]),
      .data_o    (cell_data[i])
    );
  end

  rrqs_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sum_r, FRAC_W'(0)}),
    .den   (count_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign head     = cell_data[0];
  assign head_rem = head - quantum_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    shift_en      = 1'b0;
    load_en       = 1'b0;
    load_idx      = count_r;
    load_data     = in_data.burst_time;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.result_value = '0;
          unique case (in_data.func)
            FUNC_ADD: begin
              priority if (in_data.burst_time == '0) begin
                out_item_nxt.status = ST_ZERO;
              end else if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                load_en             = 1'b1;
                count_nxt           = count_r + 1'b1;
                sum_nxt             = sum_r + SUM_W'(in_data.burst_time);
                out_item_nxt.status = ST_ADDED;
              end
            end
            FUNC_DISPATCH: begin
              priority if (count_r == '0) begin
                out_item_nxt.status = ST_EMPTY;
              end else if (head > quantum_r) begin
                shift_en                  = 1'b1;
                load_en                   = 1'b1;
                load_idx                  = count_r - 1'b1;
                load_data                 = head_rem;
                sum_nxt                   = sum_r - SUM_W'(quantum_r);
                out_item_nxt.status       = ST_REQUEUED;
                out_item_nxt.result_value = RES_W'(quantum_r);
              end else begin
                shift_en                  = 1'b1;
                count_nxt                 = count_r - 1'b1;
                sum_nxt                   = sum_r - SUM_W'(head);
                out_item_nxt.status       = ST_COMPLETED;
                out_item_nxt.result_value = RES_W'(head);
              end
            end
            default: begin
              if (count_r == '0) begin
                out_item_nxt.status = ST_AVG_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                out_item_nxt  = out_item_r;
                div_start     = 1'b1;
                state_nxt     = S_DIV;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ST_AVERAGE;
          out_item_nxt.result_value = div_quot[RES_W-1:0];
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      quantum_r   <= BURST_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ===== rtl/core/rrqs_checker.sv =====
`include "round_robin_quantum_scheduler_core_defines.svh"

module rrqs_checker
  import rrqs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input in_item_t           in_data,
  input logic               out_valid,
  input logic               out_stall,
  input out_item_t          out_data,
  input logic               cfg_we,
  input logic [BURST_W-1:0] cfg_data
);

  logic in_take;
  logic quick_func;

  assign in_take    = in_valid && !in_stall;
  assign quick_func = (in_data.func == FUNC_ADD) || (in_data.func == FUNC_DISPATCH);

  `RRQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `RRQS_ASSERT_NOW(a_no_take_when_blocked, clk, rst_n, out_valid && out_stall, in_stall)
  `RRQS_ASSERT_NEXT(a_quick_result, clk, rst_n, in_take && quick_func, out_valid)
  `RRQS_ASSERT_NEXT(a_zero_reject, clk, rst_n,
    in_take && (in_data.func == FUNC_ADD) && (in_data.burst_time == '0),
    (out_data.status == ST_ZERO) && (out_data.result_value == '0))

endmodule

bind round_robin_quantum_scheduler_core rrqs_checker u_rrqs_checker (.*);
